// ===== rtl/core/mcsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mcsr_pkg;

  localparam int RowsDefault = 64;
  localparam int ColumnsDefault = 64;
  localparam int IndexWidth = 6;
  localparam int CordicSteps = 24;
  localparam int StepWidth = 5;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [23:0] ElemMax = 24'sd8388607;
  localparam logic signed [23:0] ElemMin = -24'sd8388608;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ = 2'd1,
    CMD_SWAP = 2'd2,
    CMD_ROTATE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] row;
    logic [5:0] column_a;
    logic [5:0] column_b;
    logic signed [15:0] angle;
    logic signed [23:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] read_value;
    logic saturated;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_RD_A,
    ST_RD_B,
    ST_WAIT,
    ST_CALC,
    ST_WR_A,
    ST_WR_B,
    ST_SINGLE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic signed [15:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
  } cordic_rsp_t;

  function automatic logic signed [33:0] atan_turn(input logic [StepWidth-1:0] i);
    logic signed [33:0] t;
    case (i)
      5'd0: t = 34'sd536870912;
      5'd1: t = 34'sd316933406;
      5'd2: t = 34'sd167458907;
      5'd3: t = 34'sd85004756;
      5'd4: t = 34'sd42667331;
      5'd5: t = 34'sd21354465;
      5'd6: t = 34'sd10679838;
      5'd7: t = 34'sd5340245;
      5'd8: t = 34'sd2670163;
      5'd9: t = 34'sd1335087;
      5'd10: t = 34'sd667544;
      5'd11: t = 34'sd333772;
      5'd12: t = 34'sd166886;
      5'd13: t = 34'sd83443;
      5'd14: t = 34'sd41722;
      5'd15: t = 34'sd20861;
      5'd16: t = 34'sd10430;
      5'd17: t = 34'sd5215;
      5'd18: t = 34'sd2608;
      5'd19: t = 34'sd1304;
      5'd20: t = 34'sd652;
      5'd21: t = 34'sd326;
      5'd22: t = 34'sd163;
      5'd23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mcsr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcsr_ram #(
  parameter int Width = 24,
  parameter int Depth = 4096
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mcsr_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcsr_cordic
  import mcsr_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire cordic_req_t req,
  output cordic_rsp_t rsp
);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic flip_r, flip_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [StepWidth-1:0] i_r, i_nxt;
  logic signed [15:0] red;
  logic far;

  always_comb begin
    far = (req.angle > 16'sd16384) || (req.angle < -16'sd16384);
    red = far ? req.angle - 16'sh8000 : req.angle;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    flip_nxt = flip_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    i_nxt = i_r;
    if (req.start) begin
      x_nxt = CordicGain;
      y_nxt = '0;
      z_nxt = {{2{red[15]}}, red, 16'd0};
      flip_nxt = far;
      busy_nxt = 1'b1;
      i_nxt = '0;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - (y_r >>> i_r);
        y_nxt = y_r + (x_r >>> i_r);
        z_nxt = z_r - atan_turn(i_r);
      end else begin
        x_nxt = x_r + (y_r >>> i_r);
        y_nxt = y_r - (x_r >>> i_r);
        z_nxt = z_r + atan_turn(i_r);
      end
      i_nxt = i_r + 1'b1;
      if (i_r == StepWidth'(CordicSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    flip_r <= flip_nxt;
    i_r <= i_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.cos_v = flip_r ? -x_r : x_r;
  assign rsp.sin_v = flip_r ? -y_r : y_r;

endmodule
`default_nettype wire

// ===== rtl/core/matrix_column_swap_and_rotate_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Ports                          | Word
// input   | in_valid, in_ready, in_data    | in_word_t
// result  | out_valid, out_ready, out_data | out_word_t
// One word at a time. A write goes through ST_DONE, a read through ST_SINGLE and ST_DONE,
// and a swap through ST_RD_A, ST_RD_B, ST_WAIT, ST_WR_A, ST_WR_B per row: two reads and two writes per row.
// Rotate first runs the CORDIC (ST_CORDIC), then per row two reads, four multiply
// steps and two writes (ST_RD_A to ST_WR_B); every command ends in ST_DONE.
// Reset is synchronous and clears control only; the store is undefined until written.
// A stalled result holds; the next input word waits until the result is taken.
module matrix_column_swap_and_rotate_core
  import mcsr_pkg::*;
#(
  parameter int Rows = RowsDefault,
  parameter int Columns = ColumnsDefault
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  output logic in_ready,
  input wire in_word_t in_data,
  output logic out_valid,
  input wire logic out_ready,
  output out_word_t out_data
);

  localparam int AddrW = 2 * IndexWidth;

  state_t state_r, state_nxt;
  in_word_t cmd_r, cmd_nxt;
  logic [IndexWidth-1:0] row_r, row_nxt;
  logic [1:0] step_r, step_nxt;
  logic signed [23:0] a_r, a_nxt, b_r, b_nxt, na_r, na_nxt;
  logic signed [33:0] c_r, c_nxt, s_r, s_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic sat_r, sat_nxt;
  out_word_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [23:0] wdata, rdata;
  cordic_req_t creq;
  cordic_rsp_t crsp;

  logic in_range;
  logic signed [23:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [63:0] prod, sum, rnd;
  logic signed [23:0] sat_val;
  logic clip;

  mcsr_ram #(.Width(24), .Depth(1 << AddrW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  mcsr_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  function automatic logic [AddrW-1:0] addr(input logic [IndexWidth-1:0] r,
                                            input logic [IndexWidth-1:0] c);
    return {r, c};
  endfunction

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = res_r;
  assign prod = 64'(mul_a) * 64'(mul_b);
  assign sum = acc_r + prod + 64'sd536870912;
  assign rnd = sum >>> 30;

  always_comb begin
    sat_val = rnd[23:0];
    clip = 1'b0;
    if (rnd > 64'(ElemMax)) begin
      sat_val = ElemMax;
      clip = 1'b1;
    end else if (rnd < 64'(ElemMin)) begin
      sat_val = ElemMin;
      clip = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    row_nxt = row_r;
    step_nxt = step_r;
    a_nxt = a_r;
    b_nxt = b_r;
    na_nxt = na_r;
    c_nxt = c_r;
    s_nxt = s_r;
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    we = 1'b0;
    waddr = addr(row_r, cmd_r.column_a);
    wdata = b_r;
    raddr = addr(row_r, cmd_r.column_a);
    creq.start = 1'b0;
    creq.angle = in_data.angle;
    mul_a = a_r;
    mul_b = c_r;
    in_range = (32'(in_data.row) < Rows) && (32'(in_data.column_a) < Columns);
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_nxt = in_data;
          row_nxt = '0;
          sat_nxt = 1'b0;
          res_nxt = '0;
          raddr = addr(in_data.row, in_data.column_a);
          unique case (cmd_t'(in_data.command))
            CMD_WRITE: begin
              we = in_range;
              waddr = addr(in_data.row, in_data.column_a);
              wdata = in_data.value;
              state_nxt = ST_DONE;
            end
            CMD_READ: begin
              state_nxt = in_range ? ST_SINGLE : ST_DONE;
            end
            CMD_SWAP, CMD_ROTATE: begin
              if ((32'(in_data.column_a) < Columns) &&
                  (32'(in_data.column_b) < Columns)) begin
                if (cmd_t'(in_data.command) == CMD_ROTATE) begin
                  creq.start = 1'b1;
                  state_nxt = ST_CORDIC;
                end else begin
                  state_nxt = ST_RD_A;
                end
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SINGLE: begin
        res_nxt.read_value = rdata;
        state_nxt = ST_DONE;
      end
      ST_CORDIC: begin
        if (crsp.done) begin
          c_nxt = crsp.cos_v;
          s_nxt = crsp.sin_v;
          state_nxt = ST_RD_A;
        end
      end
      ST_RD_A: begin
        raddr = addr(row_r, cmd_r.column_a);
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        a_nxt = rdata;
        raddr = addr(row_r, cmd_r.column_b);
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        b_nxt = rdata;
        step_nxt = '0;
        state_nxt = (cmd_t'(cmd_r.command) == CMD_SWAP) ? ST_WR_A : ST_CALC;
      end
      ST_CALC: begin
        // The new a is formed first; for the same column it stands in for b.
        step_nxt = step_r + 2'd1;
        unique case (step_r)
          2'd0: begin
            mul_a = a_r;
            mul_b = c_r;
            acc_nxt = prod;
          end
          2'd1: begin
            mul_a = b_r;
            mul_b = s_r;
            na_nxt = sat_val;
            if (clip) sat_nxt = 1'b1;
          end
          2'd2: begin
            mul_a = (cmd_r.column_a == cmd_r.column_b) ? na_r : b_r;
            mul_b = c_r;
            acc_nxt = prod;
          end
          2'd3: begin
            mul_a = a_r;
            mul_b = -s_r;
            a_nxt = sat_val;
            b_nxt = na_r;
            if (clip) sat_nxt = 1'b1;
            state_nxt = ST_WR_A;
          end
        endcase
      end
      ST_WR_A: begin
        we = 1'b1;
        waddr = addr(row_r, cmd_r.column_a);
        wdata = b_r;
        state_nxt = ST_WR_B;
      end
      ST_WR_B: begin
        we = 1'b1;
        waddr = addr(row_r, cmd_r.column_b);
        wdata = a_r;
        row_nxt = row_r + IndexWidth'(1);
        state_nxt = (32'(row_r) == Rows - 1) ? ST_DONE : ST_RD_A;
      end
      ST_DONE: begin
        res_nxt.saturated = sat_r;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    row_r <= row_nxt;
    step_r <= step_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    na_r <= na_nxt;
    c_r <= c_nxt;
    s_r <= s_nxt;
    acc_r <= acc_nxt;
    sat_r <= sat_nxt;
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/mcsr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcsr_props
  import mcsr_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire out_word_t out_data,
  input wire logic out_valid,
  input wire logic out_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result waits");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

endmodule

bind matrix_column_swap_and_rotate_core mcsr_props u_mcsr_props (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
);
`default_nettype wire
